[rtl/alpl_pkg.sv]
// ----------------------------------------------------------------------------
// alpl_pkg
// Shared widths and types for the aligned part layout builder.
// ----------------------------------------------------------------------------
`default_nettype none

package alpl_pkg;

	localparam int SIZE_BITS  = 32;
	localparam int ALIGN_BITS = 17;
	localparam int CNT_BITS   = $clog2(SIZE_BITS);

	typedef logic [SIZE_BITS-1:0]  word_t;
	typedef logic [ALIGN_BITS-1:0] align_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

endpackage

`default_nettype wire

[rtl/aligned_part_layout_builder.sv]
// ----------------------------------------------------------------------------
// aligned_part_layout_builder
// Places frame parts one after another at their alignment and tracks the
// frame end, the common (lcm) alignment, the contiguous flag and overflow.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries part_size and part_alignment;
//   an alignment of zero counts as one. Output channel (out_valid/out_ready)
//   carries one result per part, in order.
//   One part is worked at a time: the offset remainder, lcm quotient and
//   padding remainder each take a serial division, the gcd is a binary gcd
//   loop of one shift or subtract per cycle, and the lcm product is a
//   shift-add. The first part skips the offset step as it has no offset to
//   round. The next transfer is taken the cycle after the result is loaded.
//   in_ready is high whenever no part is in work, also while a result waits
//   in the output register. A stalled receiver holds the result there; the
//   next part then waits at its final step until the register frees up.
//   Reset clears the frame: end 0, alignment 1, contiguous, no overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_part_layout_builder (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  alpl_pkg::word_t      part_size,
	input  alpl_pkg::align_t     part_alignment,
	output logic                 out_valid,
	input  wire                  out_ready,
	output alpl_pkg::word_t      part_offset,
	output alpl_pkg::word_t      unpadded_size,
	output alpl_pkg::word_t      padded_size,
	output alpl_pkg::word_t      common_alignment,
	output logic                 is_contiguous,
	output logic                 overflow
);

	localparam int PROD_BITS = alpl_pkg::SIZE_BITS + alpl_pkg::ALIGN_BITS;
	localparam int MCNT_BITS = $clog2(alpl_pkg::ALIGN_BITS + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_OFS_GO   = 4'd1;
	localparam logic [3:0] S_OFS_WAIT = 4'd2;
	localparam logic [3:0] S_ADD      = 4'd3;
	localparam logic [3:0] S_GCD      = 4'd4;
	localparam logic [3:0] S_Q_GO     = 4'd5;
	localparam logic [3:0] S_Q_WAIT   = 4'd6;
	localparam logic [3:0] S_MUL      = 4'd7;
	localparam logic [3:0] S_PAD_GO   = 4'd8;
	localparam logic [3:0] S_PAD_WAIT = 4'd9;
	localparam logic [3:0] S_OUT      = 4'd10;

	logic [3:0]           state_q;
	alpl_pkg::word_t      frame_end_q;
	alpl_pkg::word_t      lcm_q;
	logic                 contig_q;
	logic                 has_parts_q;
	logic                 ovf_q;
	alpl_pkg::word_t      size_q;
	alpl_pkg::align_t     al_q;
	alpl_pkg::word_t      offset_q;
	alpl_pkg::word_t      g_q;
	alpl_pkg::word_t      mcand_q;
	alpl_pkg::align_t     mplier_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [MCNT_BITS-1:0] mul_cnt_q;
	alpl_pkg::word_t      padded_q;
	logic                 out_valid_q;
	alpl_pkg::word_t      o_offset_q;
	alpl_pkg::word_t      o_unpadded_q;
	alpl_pkg::word_t      o_padded_q;
	alpl_pkg::word_t      o_align_q;
	logic                 o_contig_q;
	logic                 o_ovf_q;

	logic                 in_xfer;
	alpl_pkg::align_t     al_in;
	alpl_pkg::word_t      al_word;
	logic                 div_start;
	alpl_pkg::word_t      div_dividend;
	alpl_pkg::word_t      div_divisor;
	logic                 div_done;
	alpl_pkg::word_t      div_quo;
	alpl_pkg::word_t      div_rem;
	logic                 gcd_start;
	logic                 gcd_done;
	alpl_pkg::word_t      gcd_g;
	logic [PROD_BITS-1:0] acc_next;
	alpl_pkg::word_t      add_a;
	alpl_pkg::word_t      add_b;
	logic [alpl_pkg::SIZE_BITS:0] add_sum;
	logic                 add_sat;
	alpl_pkg::word_t      add_res;
	logic                 out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign al_in    = (part_alignment == '0) ? alpl_pkg::ALIGN_BITS'(1) : part_alignment;
	assign al_word  = {{(alpl_pkg::SIZE_BITS - alpl_pkg::ALIGN_BITS){1'b0}}, al_q};

	// one shared saturating adder; operands picked by state
	always_comb begin
		unique case (state_q)
			S_OFS_WAIT: begin
				add_a = frame_end_q;
				add_b = al_word - div_rem;
			end
			S_ADD: begin
				add_a = offset_q;
				add_b = size_q;
			end
			S_PAD_WAIT: begin
				add_a = frame_end_q;
				add_b = lcm_q - div_rem;
			end
			default: begin
				add_a = frame_end_q;
				add_b = size_q;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, add_b};
	assign add_sat = add_sum[alpl_pkg::SIZE_BITS];
	assign add_res = add_sat ? '1 : add_sum[alpl_pkg::SIZE_BITS-1:0];

	always_comb begin
		div_start = 1'b0;
		unique case (state_q)
			S_OFS_GO: begin
				div_start    = 1'b1;
				div_dividend = frame_end_q;
				div_divisor  = al_word;
			end
			S_Q_GO: begin
				div_start    = 1'b1;
				div_dividend = lcm_q;
				div_divisor  = g_q;
			end
			S_PAD_GO: begin
				div_start    = 1'b1;
				div_dividend = frame_end_q;
				div_divisor  = lcm_q;
			end
			default: begin
				div_dividend = frame_end_q;
				div_divisor  = lcm_q;
			end
		endcase
	end

	assign gcd_start = (state_q == S_ADD);

	// msb-first shift-add of quotient times alignment
	assign acc_next = {acc_q[PROD_BITS-2:0], 1'b0}
		+ (mplier_q[alpl_pkg::ALIGN_BITS-1]
			? {{alpl_pkg::ALIGN_BITS{1'b0}}, mcand_q} : {PROD_BITS{1'b0}});

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	alpl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	alpl_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (lcm_q),
		.b      (al_word),
		.done   (gcd_done),
		.g      (gcd_g)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_end_q <= '0;
			lcm_q       <= alpl_pkg::SIZE_BITS'(1);
			contig_q    <= 1'b1;
			has_parts_q <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			mul_cnt_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= has_parts_q ? S_OFS_GO : S_ADD;
					end
				end
				S_OFS_GO: begin
					state_q <= S_OFS_WAIT;
				end
				S_OFS_WAIT: begin
					if (div_done) begin
						state_q <= S_ADD;
						if (div_rem != '0) begin
							// gap before this part
							contig_q <= 1'b0;
							if (add_sat) begin
								ovf_q <= 1'b1;
							end
						end
					end
				end
				S_ADD: begin
					frame_end_q <= add_res;
					has_parts_q <= 1'b1;
					if (add_sat) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_GCD;
				end
				S_GCD: begin
					if (gcd_done) begin
						state_q <= S_Q_GO;
					end
				end
				S_Q_GO: begin
					state_q <= S_Q_WAIT;
				end
				S_Q_WAIT: begin
					if (div_done) begin
						mul_cnt_q <= MCNT_BITS'(alpl_pkg::ALIGN_BITS - 1);
						state_q   <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_cnt_q == '0) begin
						if (acc_next[PROD_BITS-1:alpl_pkg::SIZE_BITS] != '0) begin
							lcm_q <= '1;
							ovf_q <= 1'b1;
						end else begin
							lcm_q <= acc_next[alpl_pkg::SIZE_BITS-1:0];
						end
						state_q <= S_PAD_GO;
					end else begin
						mul_cnt_q <= mul_cnt_q - 1'b1;
					end
				end
				S_PAD_GO: begin
					state_q <= S_PAD_WAIT;
				end
				S_PAD_WAIT: begin
					if (div_done) begin
						if (div_rem != '0 && add_sat) begin
							ovf_q <= 1'b1;
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, loaded under the control above
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			size_q   <= part_size;
			al_q     <= al_in;
			offset_q <= '0;
		end
		if (state_q == S_OFS_WAIT && div_done) begin
			offset_q <= (div_rem == '0) ? frame_end_q : add_res;
		end
		if (state_q == S_GCD && gcd_done) begin
			g_q <= gcd_g;
		end
		if (state_q == S_Q_WAIT && div_done) begin
			mcand_q  <= div_quo;
			mplier_q <= al_q;
			acc_q    <= '0;
		end
		if (state_q == S_MUL) begin
			acc_q    <= acc_next;
			mplier_q <= {mplier_q[alpl_pkg::ALIGN_BITS-2:0], 1'b0};
		end
		if (state_q == S_PAD_WAIT && div_done) begin
			padded_q <= (div_rem == '0) ? frame_end_q : add_res;
		end
		if (out_load) begin
			o_offset_q   <= offset_q;
			o_unpadded_q <= frame_end_q;
			o_padded_q   <= padded_q;
			o_align_q    <= lcm_q;
			o_contig_q   <= contig_q;
			o_ovf_q      <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign part_offset      = o_offset_q;
	assign unpadded_size    = o_unpadded_q;
	assign padded_size      = o_padded_q;
	assign common_alignment = o_align_q;
	assign is_contiguous    = o_contig_q;
	assign overflow         = o_ovf_q;

	// overflow is sticky until reset
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("overflow flag dropped");

	// a gap once seen is never forgotten
	a_contig_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!contig_q |=> !contig_q)
		else $error("contiguous flag set again");

	// divider only reports back in a state that waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_OFS_WAIT || state_q == S_Q_WAIT
			|| state_q == S_PAD_WAIT))
		else $error("divider done outside a wait state");

	// the lcm register never holds zero
	a_lcm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lcm_q != '0)
		else $error("common alignment is zero");

endmodule

`default_nettype wire

[rtl/alpl_div.sv]
// ----------------------------------------------------------------------------
// alpl_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module alpl_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  alpl_pkg::word_t     dividend,
	input  alpl_pkg::word_t     divisor,
	output logic                done,
	output alpl_pkg::word_t     quotient,
	output alpl_pkg::word_t     remainder
);

	logic                      busy_q;
	logic                      done_q;
	alpl_pkg::cnt_t            cnt_q;
	alpl_pkg::word_t           rem_q;
	alpl_pkg::word_t           quo_q;
	alpl_pkg::word_t           dvs_q;
	logic [alpl_pkg::SIZE_BITS:0] trial;
	logic [alpl_pkg::SIZE_BITS:0] diff;
	logic                      fits;

	// next partial remainder with the next dividend bit shifted in
	assign trial = {rem_q, quo_q[alpl_pkg::SIZE_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= alpl_pkg::CNT_BITS'(alpl_pkg::SIZE_BITS - 1);
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= fits ? diff[alpl_pkg::SIZE_BITS-1:0] : trial[alpl_pkg::SIZE_BITS-1:0];
				quo_q <= {quo_q[alpl_pkg::SIZE_BITS-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

[rtl/alpl_gcd.sv]
// ----------------------------------------------------------------------------
// alpl_gcd
// Binary gcd, one shift or one subtract per cycle. Operands must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module alpl_gcd (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  alpl_pkg::word_t     a,
	input  alpl_pkg::word_t     b,
	output logic                done,
	output alpl_pkg::word_t     g
);

	logic            busy_q;
	logic            done_q;
	alpl_pkg::word_t a_q;
	alpl_pkg::word_t b_q;
	alpl_pkg::cnt_t  k_q;
	alpl_pkg::word_t g_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			a_q    <= '0;
			b_q    <= '0;
			k_q    <= '0;
			g_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				a_q    <= a;
				b_q    <= b;
				k_q    <= '0;
			end else if (busy_q) begin
				priority if (a_q == '0) begin
					g_q    <= b_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (b_q == '0) begin
					g_q    <= a_q << k_q;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (!a_q[0] && !b_q[0]) begin
					// common factor of two
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
		end
	end

	assign done = done_q;
	assign g    = g_q;

endmodule

`default_nettype wire
